// ----- sv/stlf_pkg.sv -----
// ----------------------------------------------------------------------------
// stlf_pkg
// Shared types and constants for the sync/type/length frame receiver.
// ----------------------------------------------------------------------------
package stlf_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned NUM_KINDS = 6;
  localparam int unsigned CFG_IDX_W = 3;

  // Shortest legal frame: sync, type, checksum, stop
  localparam logic [BYTE_W-1:0] LEN_MIN   = 8'd4;
  localparam logic [BYTE_W-1:0] LEN_RESET = 8'd16;

  // Known frame type codes
  localparam logic [BYTE_W-1:0] KIND_ERROR  = 8'h02;
  localparam logic [BYTE_W-1:0] KIND_ODOM   = 8'h03;
  localparam logic [BYTE_W-1:0] KIND_SONAR  = 8'h04;
  localparam logic [BYTE_W-1:0] KIND_VOLUME = 8'h05;
  localparam logic [BYTE_W-1:0] KIND_LOG    = 8'h07;
  localparam logic [BYTE_W-1:0] KIND_CONFIG = 8'h08;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BYTE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_ERROR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_ODOM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_SONAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_VOLUME  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_LOG     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_CONFIG  = 3'd7;

  // Frame status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_STOP = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_SUM  = 2'd3;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]                sync_byte;
    logic [BYTE_W-1:0]                stop_byte;
    logic [NUM_KINDS-1:0][BYTE_W-1:0] frame_len;
  } stlf_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic [BYTE_W-1:0] kind;
    logic              end_of_frame;
    logic [STAT_W-1:0] status;
  } stlf_res_t;

  // Picks the configured length for a type code; len_ok low for unknown types
  typedef struct packed {
    logic              len_ok;
    logic [BYTE_W-1:0] len;
  } kind_len_t;

  function automatic kind_len_t kind_len(input logic [BYTE_W-1:0] t,
                                         input stlf_cfg_t cfg);
    kind_len_t r;
    r.len_ok = 1'b1;
    r.len    = cfg.frame_len[0];
    case (t)
      KIND_ERROR:  r.len = cfg.frame_len[0];
      KIND_ODOM:   r.len = cfg.frame_len[1];
      KIND_SONAR:  r.len = cfg.frame_len[2];
      KIND_VOLUME: r.len = cfg.frame_len[3];
      KIND_LOG:    r.len = cfg.frame_len[4];
      KIND_CONFIG: r.len = cfg.frame_len[5];
      default:     r.len_ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/stlf_parser.sv -----
// ----------------------------------------------------------------------------
// stlf_parser
// Frame state machine: sync hunt, type decode, body count, checksum and
// stop checks. Advances by one byte on each step.
// ----------------------------------------------------------------------------
module stlf_parser import stlf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  stlf_cfg_t         cfg,
  output stlf_res_t         res
);

  localparam logic [BYTE_W-1:0] LEN_MAX = BYTE_W'(MAX_FRAME_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] flen_r, flen_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic              matched_r, matched_nxt;
  logic [BYTE_W-1:0] kind_r, kind_nxt;

  kind_len_t         kl;
  logic [BYTE_W-1:0] len_clamped;
  logic [BYTE_W-1:0] pos_ext;
  logic              last_byte;
  logic              csum_byte;
  logic              is_sync;

  assign kl      = kind_len(rx_byte, cfg);
  assign pos_ext = {1'b0, count_r};
  assign last_byte = (pos_ext + 8'd1) >= flen_r;
  assign csum_byte = (pos_ext + 8'd2) == flen_r;
  assign is_sync   = rx_byte == cfg.sync_byte;

  always_comb begin
    if (kl.len < LEN_MIN) begin
      len_clamped = LEN_MIN;
    end else if (kl.len > LEN_MAX) begin
      len_clamped = LEN_MAX;
    end else begin
      len_clamped = kl.len;
    end
  end

  // Next phase
  always_comb begin
    case (phase_r)
      PH_TYPE: phase_nxt = kl.len_ok ? PH_BODY : PH_HUNT;
      PH_BODY: phase_nxt = last_byte ? PH_HUNT : PH_BODY;
      default: phase_nxt = is_sync ? PH_TYPE : PH_HUNT;
    endcase
  end

  // Datapath and result
  always_comb begin
    count_nxt   = count_r;
    flen_nxt    = flen_r;
    sum_nxt     = sum_r;
    matched_nxt = matched_r;
    kind_nxt    = kind_r;

    res.valid         = 1'b0;
    res.frame_byte    = rx_byte;
    res.byte_position = count_r;
    res.kind          = kind_r;
    res.end_of_frame  = 1'b0;
    res.status        = ST_OK;

    case (phase_r)
      PH_TYPE: begin
        kind_nxt          = rx_byte;
        res.valid         = 1'b1;
        res.byte_position = 7'd1;
        res.kind          = rx_byte;
        if (!kl.len_ok) begin
          count_nxt        = '0;
          res.end_of_frame = 1'b1;
          res.status       = ST_BAD_TYPE;
        end else begin
          flen_nxt    = len_clamped;
          sum_nxt     = sum_r + rx_byte;
          matched_nxt = 1'b0;
          count_nxt   = 7'd2;
        end
      end
      PH_BODY: begin
        res.valid = 1'b1;
        if (last_byte) begin
          count_nxt        = '0;
          res.end_of_frame = 1'b1;
          // stop check outranks checksum check
          if (rx_byte != cfg.stop_byte) begin
            res.status = ST_BAD_STOP;
          end else if (!matched_r) begin
            res.status = ST_BAD_SUM;
          end else begin
            res.status = ST_OK;
          end
        end else begin
          if (csum_byte) begin
            matched_nxt = rx_byte == sum_r;
          end else begin
            sum_nxt = sum_r + rx_byte;
          end
          count_nxt = count_r + 7'd1;
        end
      end
      default: begin
        if (is_sync) begin
          sum_nxt     = rx_byte;
          count_nxt   = 7'd1;
          matched_nxt = 1'b0;
        end else begin
          count_nxt = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      count_r   <= '0;
      flen_r    <= '0;
      sum_r     <= '0;
      matched_r <= 1'b0;
      kind_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      flen_r    <= flen_nxt;
      sum_r     <= sum_nxt;
      matched_r <= matched_nxt;
      kind_r    <= kind_nxt;
    end
  end

endmodule

// ----- sv/sync_type_length_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// sync_type_length_frame_receiver
// Byte-stream receiver for sync/type/length framed packets with an additive
// modulo-256 checksum.
// ----------------------------------------------------------------------------
// Bytes enter on the in_ stream one per transaction. The block hunts for the
// configured sync byte, then treats the next byte as the frame type. Known
// types (2, 3, 4, 5, 7, 8) each have a configured total length, clamped to
// 4..MAX_FRAME_BYTES and latched when the type byte arrives; an unknown type
// ends the attempt at once with status bad type. Every frame byte from the
// type byte on leaves as one out_ transaction carrying the byte, its index in
// the frame (sync is index 0) and the frame type. The last byte of an attempt
// has out_tlast set and a status: 0 ok, 1 bad type, 2 bad stop byte, 3 bad
// checksum, the stop check taking priority. The checksum byte (second to
// last) must equal the modulo-256 sum of every earlier byte, sync included.
// Hunting bytes and the sync byte give no output. Throughput is one byte per
// clock cycle while out_tready does not stall the result register. An accepted
// byte sits in the input register and is then processed into the result
// register, which drives the output. Configuration writes take effect on the
// next cycle and are meant to be made while no bytes are in flight.
// ----------------------------------------------------------------------------
module sync_type_length_frame_receiver import stlf_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,

  // received byte stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,    // [7:0] rx_byte

  // frame byte stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,   // [7:0] frame_byte, [14:8] byte_position
  output logic                 out_tlast,   // end_of_frame
  output logic [9:0]           out_tuser,   // [7:0] kind, [9:8] status

  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  // Configuration registers
  stlf_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte <= '0;
      cfg_r.stop_byte <= '0;
      cfg_r.frame_len <= {NUM_KINDS{LEN_RESET}};
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SYNC_BYTE:  cfg_r.sync_byte    <= cfg_wdata;
        REG_STOP_BYTE:  cfg_r.stop_byte    <= cfg_wdata;
        REG_LEN_ERROR:  cfg_r.frame_len[0] <= cfg_wdata;
        REG_LEN_ODOM:   cfg_r.frame_len[1] <= cfg_wdata;
        REG_LEN_SONAR:  cfg_r.frame_len[2] <= cfg_wdata;
        REG_LEN_VOLUME: cfg_r.frame_len[3] <= cfg_wdata;
        REG_LEN_LOG:    cfg_r.frame_len[4] <= cfg_wdata;
        REG_LEN_CONFIG: cfg_r.frame_len[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register. The held byte is processed when the result register
  // is free or being emptied this cycle; a byte that gives no result
  // still needs that slot free, which keeps ordering simple.
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              advance;
  logic              out_valid_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Frame state machine
  stlf_res_t res;

  stlf_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Result register
  stlf_res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.byte_position, res_r.frame_byte};
  assign out_tlast  = res_r.end_of_frame;
  assign out_tuser  = {res_r.status, res_r.kind};

endmodule

// ----- tb/sv/tb_sync_type_length_frame_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_type_length_frame_receiver
// Self-checking testbench for the sync/type/length frame receiver.
// ----------------------------------------------------------------------------
// Bytes go in as in_ transactions in bursts with random gaps. The result
// stream is drained under a changing stall pattern. A scoreboard object keeps
// its own model of the framing state and the registers, works out every
// expected out_ transaction as each byte is accepted, and compares each
// received transaction field by field with the oldest one waiting.
// A short directed part is followed by random register settings, each with
// mostly well-formed frames plus corrupted, truncated and noise sequences.
// ----------------------------------------------------------------------------
module tb_sync_type_length_frame_receiver import stlf_pkg::*;;

  localparam int MAX_FRAME   = 128;
  localparam int ITEM_TARGET = 950;   // input bytes accepted
  localparam int STALL_MAX   = 20;

  // Ways a generated frame can be spoilt
  typedef enum int {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_STOP,
    FLAW_BOTH,
    FLAW_CUT
  } flaw_t;

  // Receiver back-pressure styles
  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_BURSTY
  } rx_mode_t;

  typedef struct {
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] kind;
    logic              eof;
    logic [STAT_W-1:0] status;
  } frame_res_t;

  // --------------------------------------------------------------------------
  // Scoreboard: framing model, register copy and queue of expected results
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] stop_byte;
    logic [BYTE_W-1:0] len_reg [NUM_KINDS];

    phase_t            phase;
    logic [POS_W-1:0]  byte_count;
    logic [BYTE_W-1:0] frame_length;
    logic [BYTE_W-1:0] running_sum;
    logic              sum_ok;
    logic [BYTE_W-1:0] held_kind;

    frame_res_t expected_q[$];
    int errors;
    int n_inputs;
    int n_results;
    int n_checked;
    int status_count [4];

    function new();
      sync_byte    = '0;
      stop_byte    = '0;
      foreach (len_reg[i]) len_reg[i] = LEN_RESET;
      phase        = PH_HUNT;
      byte_count   = '0;
      frame_length = '0;
      running_sum  = '0;
      sum_ok       = 1'b0;
      held_kind    = '0;
      errors       = 0;
      n_inputs     = 0;
      n_results    = 0;
      n_checked    = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      case (idx)
        REG_SYNC_BYTE: sync_byte = val;
        REG_STOP_BYTE: stop_byte = val;
        default:       len_reg[idx - REG_LEN_ERROR] = val;
      endcase
    endfunction

    function int slot_of(logic [BYTE_W-1:0] t);
      case (t)
        KIND_ERROR:  return 0;
        KIND_ODOM:   return 1;
        KIND_SONAR:  return 2;
        KIND_VOLUME: return 3;
        KIND_LOG:    return 4;
        KIND_CONFIG: return 5;
        default:     return -1;
      endcase
    endfunction

    // Configured length pulled into 4..MAX_FRAME
    function logic [BYTE_W-1:0] eff_len(int slot);
      logic [BYTE_W-1:0] v;
      v = len_reg[slot];
      if (v < LEN_MIN) return LEN_MIN;
      if (int'(v) > MAX_FRAME) return 8'(MAX_FRAME);
      return v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_expect(logic [BYTE_W-1:0] b, logic [POS_W-1:0] pos, logic eof,
                              logic [STAT_W-1:0] st);
      frame_res_t r;
      r.frame_byte = b;
      r.pos        = pos;
      r.kind       = held_kind;
      r.eof        = eof;
      r.status     = eof ? st : ST_OK;
      expected_q.insert(expected_q.size(), r);
      n_results++;
      if (eof) status_count[st]++;
    endfunction

    // One accepted input byte
    function void note_input(logic [BYTE_W-1:0] b);
      int                slot;
      logic [POS_W-1:0]  pos;
      logic [STAT_W-1:0] st;
      n_inputs++;
      case (phase)
        PH_TYPE: begin
          held_kind = b;
          slot = slot_of(b);
          if (slot < 0) begin
            phase      = PH_HUNT;
            byte_count = '0;
            push_expect(b, 7'd1, 1'b1, ST_BAD_TYPE);
          end else begin
            frame_length = eff_len(slot);
            running_sum  = running_sum + b;
            sum_ok       = 1'b0;
            byte_count   = 7'd2;
            phase        = PH_BODY;
            push_expect(b, 7'd1, 1'b0, ST_OK);
          end
        end
        PH_BODY: begin
          pos = byte_count;
          if (int'(pos) + 1 >= int'(frame_length)) begin
            if (b != stop_byte) st = ST_BAD_STOP;
            else if (!sum_ok)   st = ST_BAD_SUM;
            else                st = ST_OK;
            phase      = PH_HUNT;
            byte_count = '0;
            push_expect(b, pos, 1'b1, st);
          end else begin
            if (int'(pos) + 2 == int'(frame_length)) sum_ok = (b == running_sum);
            else running_sum = running_sum + b;
            byte_count = pos + 7'd1;
            push_expect(b, pos, 1'b0, ST_OK);
          end
        end
        default: begin
          if (b == sync_byte) begin
            phase       = PH_TYPE;
            running_sum = b;
            byte_count  = 7'd1;
            sum_ok      = 1'b0;
          end else begin
            phase      = PH_HUNT;
            byte_count = '0;
          end
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
               n_checked, what, got, want);
      errors++;
    endtask

    // One received out_ transaction
    task check_result(logic [15:0] tdata, logic tlast, logic [9:0] tuser);
      frame_res_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        report("unexpected transaction, tdata", 32'(tdata), 32'hffff_ffff);
        return;
      end
      e = expected_q.pop_front();
      if (tdata[7:0]  !== e.frame_byte) report("frame_byte", 32'(tdata[7:0]), 32'(e.frame_byte));
      if (tdata[14:8] !== e.pos)        report("byte_position", 32'(tdata[14:8]), 32'(e.pos));
      if (tdata[15]   !== 1'b0)         report("tdata padding", 32'(tdata[15]), 32'd0);
      if (tuser[7:0]  !== e.kind)       report("kind", 32'(tuser[7:0]), 32'(e.kind));
      if (tlast       !== e.eof)        report("end_of_frame", 32'(tlast), 32'(e.eof));
      if (tuser[9:8]  !== e.status)     report("status", 32'(tuser[9:8]), 32'(e.status));
    endtask

    task close_out();
      if (expected_q.size() != 0)
        report("results still outstanding", 32'(expected_q.size()), 32'd0);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic                 out_tlast;
  logic [9:0]           out_tuser;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [BYTE_W-1:0]    cfg_wdata  = '0;

  always #5 clk = ~clk;

  sync_type_length_frame_receiver #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [7:0] rx_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // [7:0] frame_byte, [14:8] byte_position
    .out_tlast  (out_tlast),    // end_of_frame
    .out_tuser  (out_tuser),    // [7:0] kind, [9:8] status
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  frame_scoreboard sb;

  // Hard stop in case the DUT hangs
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: check each accepted transaction, then choose next tready.
  // Values sampled here are the ones present at the edge.
  // --------------------------------------------------------------------------
  rx_mode_t rx_mode    = RX_FREE;
  int       rx_cycle   = 0;
  int       stall_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
      rx_cycle++;
      // swap back-pressure style every so often so stalls land everywhere
      if (rx_cycle % 200 == 0) rx_mode = rx_mode_t'($urandom_range(0, 2));
      case (rx_mode)
        RX_FREE:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_tready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, STALL_MAX);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int n_settings = 0;

  // Offer one byte and hold it until the transaction completes. tvalid stays
  // high between bytes of a burst and is dropped only for a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        gap        = 0;                      // long stretch with no idling
        burst_left = $urandom_range(60, 200);
      end else begin
        gap        = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 24);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(b);
  endtask

  // Stop sending and wait until every expected result has come out, then let
  // the two-stage pipe empty of any hunting bytes still in it.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves the write enable high so back-to-back writes need no toggle;
  // the caller drops it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Builds a frame for the current settings; flaws spoil checksum, stop or
  // cut the frame short so the next sync is swallowed as payload.
  task automatic send_frame(input logic [7:0] kind, input flaw_t flaw);
    int         slot;
    int         len;
    int         cut;
    int         i;
    logic [7:0] sum;
    logic [7:0] b;
    slot = sb.slot_of(kind);
    len  = (slot < 0) ? 2 : int'(sb.eff_len(slot));
    cut  = (flaw == FLAW_CUT && len > 2) ? $urandom_range(2, len - 1) : len;
    sum  = sb.sync_byte + kind;
    send_byte(sb.sync_byte);
    send_byte(kind);
    for (i = 2; i < cut; i++) begin
      if (i == len - 1) begin
        b = sb.stop_byte;
        if (flaw == FLAW_STOP || flaw == FLAW_BOTH) b = b ^ 8'($urandom_range(1, 255));
      end else if (i == len - 2) begin
        b = sum;
        if (flaw == FLAW_SUM || flaw == FLAW_BOTH) b = b ^ 8'($urandom_range(1, 255));
      end else begin
        b   = 8'($urandom_range(0, 255));
        sum = sum + b;
      end
      send_byte(b);
    end
  endtask

  function automatic logic [7:0] known_kind(int i);
    case (i)
      0:       return KIND_ERROR;
      1:       return KIND_ODOM;
      2:       return KIND_SONAR;
      3:       return KIND_VOLUME;
      4:       return KIND_LOG;
      default: return KIND_CONFIG;
    endcase
  endfunction

  // Length register value, out-of-range values included
  function automatic logic [7:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return LEN_MIN;
      1:       return 8'(MAX_FRAME);
      2:       return 8'($urandom_range(0, 3));
      3:       return 8'($urandom_range(MAX_FRAME + 1, 255));
      default: return 8'($urandom_range(4, 12));
    endcase
  endfunction

  function automatic logic [7:0] pick_marker();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // First setting is all minimum lengths, second all maximum, then random
  task automatic program_setting();
    int i;
    case (n_settings)
      0: begin
        write_reg(REG_SYNC_BYTE, 8'h00);
        write_reg(REG_STOP_BYTE, 8'hff);
        for (i = 0; i < NUM_KINDS; i++)
          write_reg(REG_LEN_ERROR + 3'(i), (i % 2) ? LEN_MIN : 8'($urandom_range(0, 3)));
      end
      1: begin
        write_reg(REG_SYNC_BYTE, 8'hff);
        write_reg(REG_STOP_BYTE, 8'h00);
        for (i = 0; i < NUM_KINDS; i++)
          write_reg(REG_LEN_ERROR + 3'(i), (i % 2) ? 8'(MAX_FRAME) : 8'hff);
      end
      default: begin
        write_reg(REG_SYNC_BYTE, pick_marker());
        write_reg(REG_STOP_BYTE, pick_marker());
        for (i = 0; i < NUM_KINDS; i++) write_reg(REG_LEN_ERROR + 3'(i), pick_len());
      end
    endcase
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // Mostly clean frames with random content; the rest broken or noise
  task automatic send_random_unit();
    int r;
    int i;
    r = $urandom_range(0, 99);
    if (r < 68)      send_frame(known_kind($urandom_range(0, 5)), FLAW_NONE);
    else if (r < 78) send_frame(known_kind($urandom_range(0, 5)),
                                flaw_t'($urandom_range(FLAW_SUM, FLAW_BOTH)));
    else if (r < 85) send_frame(known_kind($urandom_range(0, 5)), FLAW_CUT);
    else if (r < 92) send_frame(8'($urandom_range(0, 255)), FLAW_NONE);
    else begin
      for (i = 0; i < $urandom_range(1, 4); i++) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_target;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sync A5, stop 5A, short lengths for three kinds
    write_reg(REG_SYNC_BYTE, 8'ha5);
    write_reg(REG_STOP_BYTE, 8'h5a);
    write_reg(REG_LEN_ERROR, LEN_MIN);
    write_reg(REG_LEN_ODOM,  8'd5);
    write_reg(REG_LEN_SONAR, 8'd6);
    cfg_wr_en <= 1'b0;

    // hunting noise at both byte extremes, dropped silently
    send_byte(8'h00);
    send_byte(8'hff);
    // unknown types at both extremes
    send_byte(8'ha5);
    send_byte(8'h00);
    send_byte(8'ha5);
    send_byte(8'hff);
    // shortest frame: clean, bad checksum, bad stop with bad checksum, bad stop
    send_frame(KIND_ERROR, FLAW_NONE);
    send_frame(KIND_ERROR, FLAW_SUM);
    send_frame(KIND_ERROR, FLAW_BOTH);
    send_frame(KIND_ERROR, FLAW_STOP);
    // sync value inside a frame is plain payload
    send_byte(8'ha5);
    send_byte(KIND_ODOM);
    send_byte(8'ha5);
    send_byte(8'(8'ha5 + KIND_ODOM + 8'ha5));
    send_byte(8'h5a);
    // length rewritten mid-frame: the frame in progress keeps its length
    send_byte(8'ha5);
    send_byte(KIND_SONAR);
    send_byte(8'h11);
    wait_idle();
    write_reg(REG_LEN_SONAR, LEN_MIN);
    cfg_wr_en <= 1'b0;
    send_byte(8'h22);
    send_byte(8'(8'ha5 + KIND_SONAR + 8'h11 + 8'h22));
    send_byte(8'h5a);
    // ...and the next one uses the new length
    send_frame(KIND_SONAR, FLAW_NONE);

    // Random part, one register setting per pass; each pass starts with the
    // sender held off until every expected result has arrived
    while (sb.n_inputs < ITEM_TARGET) begin
      wait_idle();
      program_setting();
      phase_target = sb.n_inputs + $urandom_range(40, 120);
      while (sb.n_inputs < phase_target && sb.n_inputs < ITEM_TARGET)
        send_random_unit();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    sb.close_out();

    $display("Sent %0d bytes, checked %0d frame bytes under %0d register settings.",
             sb.n_inputs, sb.n_checked, n_settings);
    $display("Attempts ended ok %0d, bad type %0d, bad stop %0d, bad checksum %0d.",
             sb.status_count[ST_OK], sb.status_count[ST_BAD_TYPE],
             sb.status_count[ST_BAD_STOP], sb.status_count[ST_BAD_SUM]);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
